FILE: sv/alfr_pkg.sv
`default_nettype none

package alfr_pkg;

	localparam int RateW   = 16;
	localparam int TimeW   = 20;
	localparam int SumW    = 25;
	localparam int TargetW = 12;
	localparam int TolW    = 10;
	localparam int GainW   = 24;
	localparam int MaxW    = 10;
	localparam int ChangeW = 11;
	localparam int CfgIdxW = 3;
	localparam int CfgW    = 24;
	localparam int DivW    = ChangeW + 16;
	localparam int DivCntW = 5;

	localparam logic [GainW-1:0]   GAIN_MAX   = 24'hFFFFFF;
	localparam logic [GainW-1:0]   GAIN_FLOOR = 24'd41;
	localparam logic [GainW-1:0]   GAIN_RESET = 24'd4096;
	localparam logic [GainW-1:0]   DIP_MAG    = 24'd10;
	localparam logic [DivCntW-1:0] DIV_STEPS  = 5'd27;

	typedef enum logic [CfgIdxW-1:0] {
		REG_TARGET    = 3'd0,
		REG_TOLERANCE = 3'd1,
		REG_INTERVAL  = 3'd2,
		REG_FALLBACK  = 3'd3,
		REG_MAX       = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [TargetW-1:0] target_rate;
		logic [TolW-1:0]    rate_tolerance;
		logic [GainW-1:0]   update_interval;
		logic [GainW-1:0]   fallback_gain;
		logic [MaxW-1:0]    max_change;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic clr_time;
		logic clr_await;
		logic gain_fb;
		logic gain_max;
		logic div_start;
		logic mul_start;
		logic finish;
		logic res_zero;
		logic push;
	} cmd_t;

	typedef struct packed {
		logic fire;
		logic awaiting;
		logic small_drop;
		logic zero_drop;
		logic out_range;
		logic div_done;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

FILE: sv/alfr_regs.sv
`default_nettype none

module alfr_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [alfr_pkg::CfgIdxW-1:0] cfg_index,
	input  wire logic [alfr_pkg::CfgW-1:0]    cfg_data,
	output alfr_pkg::cfg_t                    cfg
);
	import alfr_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_rate     <= 12'd60;
			cfg_q.rate_tolerance  <= 10'd5;
			cfg_q.update_interval <= 24'd1000000;
			cfg_q.fallback_gain   <= 24'd4096;
			cfg_q.max_change      <= 10'd100;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TARGET:    cfg_q.target_rate     <= cfg_data[TargetW-1:0];
				REG_TOLERANCE: cfg_q.rate_tolerance  <= cfg_data[TolW-1:0];
				REG_INTERVAL:  cfg_q.update_interval <= cfg_data[GainW-1:0];
				REG_FALLBACK:  cfg_q.fallback_gain   <= cfg_data[GainW-1:0];
				REG_MAX:       cfg_q.max_change      <= cfg_data[MaxW-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: sv/alfr_ctrl.sv
`default_nettype none

module alfr_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire alfr_pkg::status_t st,
	output alfr_pkg::cmd_t     cmd
);
	import alfr_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_DIV,
		S_CHK,
		S_MUL,
		S_OUT
	} state_t;

	state_t state_q;
	logic   stall_q;
	logic   accept;

	assign accept   = in_valid && !stall_q;
	assign in_stall = stall_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = accept;
			end
			S_EVAL: begin
				if (st.fire) begin
					cmd.clr_time  = 1'b1;
					cmd.clr_await = st.awaiting;
					if (st.awaiting) begin
						if (st.small_drop) begin
							cmd.gain_fb = 1'b1;
						end else if (st.zero_drop) begin
							cmd.gain_max = 1'b1;
						end else begin
							cmd.div_start = 1'b1;
						end
					end
				end else begin
					cmd.res_zero = 1'b1;
				end
			end
			S_DIV: begin
			end
			S_CHK: begin
				if (st.out_range) begin
					cmd.mul_start = 1'b1;
				end else begin
					cmd.res_zero = 1'b1;
				end
			end
			S_MUL: begin
				cmd.finish = 1'b1;
			end
			S_OUT: begin
				cmd.push = st.out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stall_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EVAL;
						stall_q <= 1'b1;
					end
				end
				S_EVAL: begin
					if (!st.fire) begin
						state_q <= S_OUT;
					end else if (st.awaiting && !st.small_drop && !st.zero_drop) begin
						state_q <= S_DIV;
					end else begin
						state_q <= S_CHK;
					end
				end
				S_DIV: begin
					if (st.div_done) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					state_q <= st.out_range ? S_MUL : S_OUT;
				end
				S_MUL: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (st.out_free) begin
						state_q <= S_IDLE;
						stall_q <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
					stall_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: sv/alfr_dp.sv
`default_nettype none

module alfr_dp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire alfr_pkg::cfg_t                      cfg,
	input  wire alfr_pkg::cmd_t                      cmd,
	output alfr_pkg::status_t                        st,
	input  wire logic [alfr_pkg::RateW-1:0]          frame_rate,
	input  wire logic [alfr_pkg::TimeW-1:0]          frame_time,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed [alfr_pkg::ChangeW-1:0]      load_change
);
	import alfr_pkg::*;

	logic [RateW-1:0]           avg_q;
	logic                       dip_q;
	logic [SumW-1:0]            time_q;
	logic                       await_q;
	logic [RateW-1:0]           rbc_q;
	logic [ChangeW-1:0]         last_q;
	logic [GainW-1:0]           gain_q;
	logic [15:0]                rem_q;
	logic [DivW-1:0]            quo_q;
	logic [DivCntW-1:0]         cnt_q;
	logic                       div_busy_q;
	logic [GainW+RateW-1:0]     prod_q;
	logic                       eneg_q;
	logic [ChangeW-1:0]         res_q;
	logic                       out_valid_q;
	logic [ChangeW-1:0]         out_q;

	logic [RateW:0]             avg_sum;
	logic [SumW:0]              time_sum;
	logic signed [13:0]         low14;
	logic [13:0]                high14;
	logic signed [17:0]         low_b;
	logic [17:0]                high_b;
	logic                       rate_low;
	logic [RateW:0]             drop;
	logic [RateW-1:0]           drop_mag;
	logic [ChangeW-1:0]         last_mag;
	logic [17:0]                trial;
	logic [15:0]                rem_nx;
	logic [DivW-1:0]            quo_nx;
	logic [GainW-1:0]           quo_sat;
	logic [GainW-1:0]           gain_eff;
	logic [RateW:0]             err;
	logic [RateW-1:0]           err_mag;
	logic [GainW-1:0]           mag;
	logic                       force_dip;
	logic [GainW-1:0]           sel_mag;
	logic                       sel_neg;
	logic [MaxW-1:0]            clamped;
	logic [ChangeW-1:0]         change;

	assign avg_sum  = {1'b0, avg_q} + {1'b0, frame_rate};
	assign time_sum = {1'b0, time_q} + {6'b0, frame_time};
	assign low14    = $signed({2'b0, cfg.target_rate}) - $signed({4'b0, cfg.rate_tolerance});
	assign high14   = {2'b0, cfg.target_rate} + {3'b0, cfg.rate_tolerance, 1'b0};
	assign low_b    = {low14, 4'b0};
	assign high_b   = {high14, 4'b0};
	assign rate_low = $signed({2'b0, frame_rate}) < low_b;

	assign drop     = {1'b0, rbc_q} - {1'b0, avg_q};
	assign drop_mag = drop[RateW] ? RateW'(-drop) : drop[RateW-1:0];
	assign last_mag = last_q[ChangeW-1] ? ChangeW'(-last_q) : last_q;

	assign trial   = {1'b0, rem_q, quo_q[DivW-1]} - {2'b0, drop_mag};
	assign rem_nx  = trial[17] ? {rem_q[14:0], quo_q[DivW-1]} : trial[15:0];
	assign quo_nx  = {quo_q[DivW-2:0], !trial[17]};
	assign quo_sat = (|quo_nx[DivW-1:GainW]) ? GAIN_MAX : quo_nx[GainW-1:0];

	assign gain_eff = (gain_q == '0) ? GAIN_FLOOR : gain_q;
	assign err      = {1'b0, avg_q} - {1'b0, cfg.target_rate, 4'b0};
	assign err_mag  = err[RateW] ? RateW'(-err) : err[RateW-1:0];

	assign mag       = prod_q[GainW+RateW-1:RateW];
	assign force_dip = dip_q && !eneg_q && (mag != '0);
	assign sel_mag   = force_dip ? DIP_MAG : mag;
	assign sel_neg   = force_dip || eneg_q;
	assign clamped   = (sel_mag > {14'b0, cfg.max_change}) ? cfg.max_change : sel_mag[MaxW-1:0];
	assign change    = sel_neg ? ChangeW'(-{1'b0, clamped}) : {1'b0, clamped};

	assign st.fire       = time_q > {1'b0, cfg.update_interval};
	assign st.awaiting   = await_q;
	assign st.small_drop = {drop_mag, 8'b0} < cfg.fallback_gain;
	assign st.zero_drop  = drop_mag == '0;
	assign st.out_range  = ($signed({2'b0, avg_q}) < low_b) || ({2'b0, avg_q} > high_b);
	assign st.div_done   = div_busy_q && (cnt_q == DivCntW'(1));
	assign st.out_free   = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q       <= '0;
			dip_q       <= 1'b0;
			time_q      <= '0;
			await_q     <= 1'b0;
			rbc_q       <= '0;
			last_q      <= '0;
			gain_q      <= GAIN_RESET;
			div_busy_q  <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				avg_q  <= avg_sum[RateW:1];
				time_q <= time_sum[SumW] ? {SumW{1'b1}} : time_sum[SumW-1:0];
				if (rate_low) begin
					dip_q <= 1'b1;
				end
			end
			if (cmd.clr_time) begin
				time_q <= '0;
			end
			if (cmd.clr_await) begin
				await_q <= 1'b0;
			end
			if (cmd.gain_fb) begin
				gain_q <= cfg.fallback_gain;
			end
			if (cmd.gain_max) begin
				gain_q <= GAIN_MAX;
			end
			if (cmd.div_start) begin
				div_busy_q <= 1'b1;
				cnt_q      <= DIV_STEPS;
			end else if (div_busy_q) begin
				cnt_q <= cnt_q - DivCntW'(1);
				if (cnt_q == DivCntW'(1)) begin
					div_busy_q <= 1'b0;
					gain_q     <= quo_sat;
				end
			end
			if (cmd.finish) begin
				last_q  <= change;
				rbc_q   <= avg_q;
				await_q <= 1'b1;
				if (force_dip) begin
					dip_q <= 1'b0;
				end
			end
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= '0;
			quo_q <= {last_mag, 16'b0};
		end else if (div_busy_q) begin
			rem_q <= rem_nx;
			quo_q <= quo_nx;
		end
		if (cmd.mul_start) begin
			prod_q <= (GainW+RateW)'(gain_eff) * (GainW+RateW)'(err_mag);
			eneg_q <= err[RateW];
		end
		if (cmd.res_zero) begin
			res_q <= '0;
		end else if (cmd.finish) begin
			res_q <= change;
		end
		if (cmd.push) begin
			out_q <= res_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign load_change = $signed(out_q);

endmodule

`default_nettype wire

FILE: sv/adaptive_load_from_frame_rate.sv
// Load controller that suggests a change of rendering load from measured frame rates.
// Input channel (in_valid / in_stall): one beat per frame carries frame_rate (Q12.4)
// and frame_time in microseconds. Output channel (out_valid / out_stall): exactly
// one beat per input beat carries the signed load_change, zero when no change is due.
// Configuration is written through cfg_we, cfg_index and cfg_data, by the user only
// while the block is idle (the block does not enforce it); unknown indexes are ignored.
// The block works on one frame at a time. A frame that does not close an update
// interval goes straight to the output stage. A frame that closes an interval may
// re-estimate the gain with the 27-step bit-serial divider and, when the average is
// out of range, goes through the multiply and clamp steps.
// A new frame is taken in the cycle after its predecessor's result moves into the
// output register, so a finished result may still wait there while the next
// frame is at work. If the receiver stalls, the result holds steady and the block
// waits with its next result until the output register is free.
// Reset clears the rate average, time sum, dip flag and pending measurement,
// sets the gain to one load unit per frame rate and loads the register defaults.
`default_nettype none

module adaptive_load_from_frame_rate (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [alfr_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [alfr_pkg::CfgW-1:0]      cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [alfr_pkg::RateW-1:0]     frame_rate,
	input  wire logic [alfr_pkg::TimeW-1:0]     frame_time,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic signed [alfr_pkg::ChangeW-1:0] load_change
);
	import alfr_pkg::*;

	cfg_t    cfg;
	cmd_t    cmd;
	status_t st;

	alfr_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	alfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	alfr_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.st          (st),
		.frame_rate  (frame_rate),
		.frame_time  (frame_time),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.load_change (load_change)
	);

endmodule

`default_nettype wire

FILE: sv/alfr_chk.sv
`default_nettype none

module alfr_chk (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	input  wire logic                           in_stall,
	input  wire logic                           out_valid,
	input  wire logic                           out_stall,
	input  wire logic signed [alfr_pkg::ChangeW-1:0] load_change
);
	import alfr_pkg::*;

	// A held result beat keeps its value until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(load_change))
		else $error("output beat changed while stalled");

	// Only one frame is in work at a time.
	a_one_frame: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second frame taken while busy");

	// A new result only appears while a frame is in work.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a frame in work");

	// Clamping keeps the change within the ten-bit magnitude.
	a_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> load_change != -11'sd1024)
		else $error("load change outside the clamp range");

endmodule

bind adaptive_load_from_frame_rate alfr_chk u_alfr_chk (.*);

`default_nettype wire

FILE: dv/alfr_checker.sv
`default_nettype none

module alfr_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [alfr_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [alfr_pkg::CfgW-1:0]      cfg_data,
	input  wire logic                           in_valid,
	input  wire logic                           in_stall,
	input  wire logic [alfr_pkg::RateW-1:0]     frame_rate,
	input  wire logic [alfr_pkg::TimeW-1:0]     frame_time,
	input  wire logic                           out_valid,
	input  wire logic                           out_stall,
	input  wire logic signed [alfr_pkg::ChangeW-1:0] load_change,
	output int                                  mismatches,
	output int                                  changes_owed,
	output int                                  nonzero_changes
);

	import alfr_pkg::*;

	logic [TargetW-1:0] target;
	logic [TolW-1:0]    tol;
	logic [GainW-1:0]   interval;
	logic [GainW-1:0]   fallback;
	logic [MaxW-1:0]    max_chg;

	logic [RateW-1:0]          avg;
	logic [RateW-1:0]          rate_at_change;
	logic                      dip;
	logic [SumW-1:0]           time_acc;
	logic                      awaiting;
	logic signed [ChangeW-1:0] prev_change;
	logic [GainW-1:0]          gain;

	logic signed [ChangeW-1:0] changes_due[$];

	function automatic longint lower_limit();
		return (longint'(target) - longint'(tol)) * 16;
	endfunction

	function automatic longint upper_limit();
		return (longint'(target) + 2 * longint'(tol)) * 16;
	endfunction

	task automatic reestimate_gain();
		longint drop;
		longint unsigned mag_drop;
		longint unsigned mag_chg;
		longint unsigned g;
		drop = longint'(rate_at_change) - longint'(avg);
		mag_drop = drop < 0 ? -drop : drop;
		if ((mag_drop << 8) < fallback) begin
			gain = fallback;
		end else if (mag_drop == 0) begin
			gain = GAIN_MAX;
		end else begin
			mag_chg = prev_change < 0 ? -longint'(prev_change) : longint'(prev_change);
			g = (mag_chg << 16) / mag_drop;
			gain = g > GAIN_MAX ? GAIN_MAX : g[GainW-1:0];
		end
	endtask

	task automatic scaled_change(output logic signed [ChangeW-1:0] chg);
		longint unsigned g;
		longint unsigned abs_err;
		longint err;
		longint est;
		longint lim;
		g = gain == 0 ? GAIN_FLOOR : gain;
		err = longint'(avg) - longint'(target) * 16;
		abs_err = err < 0 ? -err : err;
		est = longint'((g * abs_err) >> 16);
		if (err < 0) begin
			est = -est;
		end
		lim = longint'(max_chg);
		// A pending dip turns any increase of load into a decrease of DIP_MAG and is then cleared.
		if (dip && est > 0) begin
			dip = 1'b0;
			est = -longint'(DIP_MAG);
		end
		if (est > lim) begin
			est = lim;
		end
		if (est < -lim) begin
			est = -lim;
		end
		chg = est[ChangeW-1:0];
	endtask

	task automatic advance_controller(input logic [RateW-1:0] rate, input logic [TimeW-1:0] ftime,
			output logic signed [ChangeW-1:0] chg);
		logic [RateW:0] s;
		logic [SumW:0]  t;
		chg = '0;
		s = avg + rate;
		avg = s[RateW:1];
		if (longint'(rate) < lower_limit()) begin
			dip = 1'b1;
		end
		t = time_acc + ftime;
		time_acc = t[SumW] ? '1 : t[SumW-1:0];
		if (time_acc > interval) begin
			time_acc = '0;
			if (awaiting) begin
				reestimate_gain();
				awaiting = 1'b0;
			end
			if (longint'(avg) < lower_limit() || longint'(avg) > upper_limit()) begin
				scaled_change(chg);
				prev_change = chg;
				rate_at_change = avg;
				awaiting = 1'b1;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		logic signed [ChangeW-1:0] chg;
		if (!arst_n) begin
			target = 12'd60;
			tol = 10'd5;
			interval = 24'd1000000;
			fallback = GAIN_RESET;
			max_chg = 10'd100;
			avg = '0;
			rate_at_change = '0;
			dip = 1'b0;
			time_acc = '0;
			awaiting = 1'b0;
			prev_change = '0;
			gain = GAIN_RESET;
			changes_due.delete();
			mismatches = 0;
			nonzero_changes = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TARGET: target = cfg_data[TargetW-1:0];
					REG_TOLERANCE: tol = cfg_data[TolW-1:0];
					REG_INTERVAL: interval = cfg_data[GainW-1:0];
					REG_FALLBACK: fallback = cfg_data[GainW-1:0];
					REG_MAX: max_chg = cfg_data[MaxW-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (changes_due.size() == 0) begin
					$error("load_change: expected none, actual %0d", load_change);
					mismatches++;
				end else begin
					chg = changes_due.pop_front();
					if (chg !== load_change) begin
						$error("load_change: expected %0d, actual %0d", chg, load_change);
						mismatches++;
					end
					if (chg != 0) begin
						nonzero_changes++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				advance_controller(frame_rate, frame_time, chg);
				changes_due.push_back(chg);
			end
		end
		changes_owed = changes_due.size();
	end

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
`default_nettype none

module tb_top;

	import alfr_pkg::*;

	localparam int QuietLimit = 4000;
	localparam int Phases     = 12;
	localparam int PhaseBeats = 119;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [CfgIdxW-1:0]        cfg_index = '0;
	logic [CfgW-1:0]           cfg_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [RateW-1:0]          frame_rate = '0;
	logic [TimeW-1:0]          frame_time = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic signed [ChangeW-1:0] load_change;

	int mismatches;
	int changes_owed;
	int nonzero_changes;

	int idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;
	int frames_sent = 0;
	int writes_done = 0;
	int cur_target = 60;
	int cur_tol = 5;
	int cur_interval = 1000000;

	adaptive_load_from_frame_rate uut (.*);
	alfr_checker chk (.*);

	always #2 clk = ~clk;

	always @(negedge clk) begin
		out_stall = $urandom_range(99) < stall_pct;
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles = quiet_cycles + 1;
		end
		if (quiet_cycles >= QuietLimit) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	task automatic set_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		writes_done++;
	endtask

	task automatic settle();
		in_valid = 1'b0;
		while (changes_owed != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic send_frame(input logic [RateW-1:0] r, input logic [TimeW-1:0] t);
		while ($urandom_range(99) < idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		frame_rate = r;
		frame_time = t;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		frames_sent++;
	endtask

	function automatic int pick_value(input int bias, input int lo, input int hi, input int mid);
		int sel;
		sel = bias == 1 ? 0 : bias == 2 ? 1 : $urandom_range(7);
		return sel == 0 ? lo : sel == 1 ? hi : mid;
	endfunction

	function automatic logic [RateW-1:0] rate_near_target();
		longint spread;
		longint v;
		spread = longint'(cur_tol) * 48 + 80;
		v = longint'(cur_target) * 16 - spread + $urandom_range(0, 2 * spread);
		if (v < 0) begin
			v = 0;
		end
		if (v > 65535) begin
			v = 65535;
		end
		return v[RateW-1:0];
	endfunction

	task automatic pick_config(input int bias);
		cur_target = pick_value(bias, 0, 4095, $urandom_range(20, 240));
		cur_tol = pick_value(bias, 0, 1023, $urandom_range(1, 30));
		cur_interval = pick_value(bias, 0, 16777215, $urandom_range(1000, 200000));
		set_reg(REG_TARGET, CfgW'(cur_target));
		set_reg(REG_TOLERANCE, CfgW'(cur_tol));
		set_reg(REG_INTERVAL, CfgW'(cur_interval));
		set_reg(REG_FALLBACK, CfgW'(pick_value(bias, 0, 16777215, $urandom_range(256, 32768))));
		set_reg(REG_MAX, CfgW'(pick_value(bias, 0, 1023, $urandom_range(5, 300))));
		set_reg(CfgIdxW'(REG_MAX) + CfgIdxW'($urandom_range(1, 3)), CfgW'($urandom));
	endtask

	task automatic run_phase(input int mode, input int count);
		logic [RateW-1:0] r;
		logic [RateW-1:0] prev;
		longint span;
		int sel;
		case (mode)
			0: begin idle_pct = 0; stall_pct = 0; end
			1: begin idle_pct = 62; stall_pct = 0; end
			2: begin idle_pct = 0; stall_pct = 62; end
			default: begin idle_pct = 27; stall_pct = 27; end
		endcase
		prev = rate_near_target();
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(99);
			if (sel < 15) begin
				r = RateW'($urandom);
				send_frame(r, TimeW'($urandom));
			end else begin
				r = sel < 30 ? prev : rate_near_target();
				span = 2 * longint'(cur_interval) / $urandom_range(1, 4) + 1;
				if (span > 1048575) begin
					span = 1048575;
				end
				send_frame(r, TimeW'($urandom_range(0, span)));
			end
			prev = r;
		end
	endtask

	initial begin : stimulus
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_frame(16'd0, 20'd0);
		send_frame(16'hFFFF, 20'hFFFFF);
		send_frame(16'hFFFF, 20'hFFFFF);
		send_frame(16'd960, 20'hFFFFF);
		repeat (3) send_frame(16'd1200, 20'hFFFFF);
		repeat (2) send_frame(16'd0, 20'hFFFFF);
		repeat (2) send_frame(16'd960, 20'd500000);
		send_frame(16'd960, 20'd1);

		settle();
		set_reg(REG_FALLBACK, '0);
		set_reg(REG_MAX, CfgW'(1023));
		set_reg(REG_INTERVAL, '0);
		repeat (3) send_frame(16'd1200, 20'd1);
		settle();
		set_reg(REG_MAX, '0);
		send_frame(16'd1300, 20'd1);
		send_frame(16'd1400, 20'd1);
		settle();
		set_reg(REG_MAX, CfgW'(1023));
		send_frame(16'd1500, 20'd1);
		send_frame(16'd1600, 20'd1);
		send_frame(16'd1000, 20'd0);

		for (int ph = 0; ph < Phases; ph++) begin
			settle();
			pick_config(ph == 0 ? 1 : ph == 1 ? 2 : 0);
			run_phase(ph % 4, PhaseBeats);
		end

		settle();
		repeat (40) @(posedge clk);
		$display("Run covered %0d frames and %0d register writes over %0d register settings,",
			frames_sent, writes_done, Phases + 4);
		$display("with %0d nonzero load changes checked under all four idle patterns.",
			nonzero_changes);
		if (mismatches == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule

`default_nettype wire
